/* sv/scdps_pkg.sv */
package scdps_pkg;

	// Duty format: unsigned, DUTY_FRAC_BITS fraction bits, one integer bit
	localparam int DUTY_FRAC_BITS = 16;
	localparam int DUTY_W         = DUTY_FRAC_BITS + 1;
	localparam int TIMER_BITS     = 24;

	// Field widths
	localparam int ELAPSED_W  = 20;
	localparam int RATE_W     = 16;
	localparam int CFG_TIME_W = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int PHASE_W    = 3;
	localparam int RATE_SHIFT = 8;
	localparam int PROD_W     = RATE_W + ELAPSED_W;
	localparam int DELTA_W    = PROD_W - RATE_SHIFT;

	// Duty levels: 1.0, above-0.99 threshold, below-0.76 threshold, 0.75 floor
	localparam logic [DUTY_W-1:0] DUTY_ONE   = DUTY_W'(64'd1 << DUTY_FRAC_BITS);
	localparam logic [DUTY_W-1:0] TH_HIGH    =
		DUTY_W'(((64'd1 << DUTY_FRAC_BITS) * 64'd99) / 64'd100);
	localparam logic [DUTY_W-1:0] TH_LOW     =
		DUTY_W'(((64'd1 << DUTY_FRAC_BITS) * 64'd76 + 64'd99) / 64'd100);
	localparam logic [DUTY_W-1:0] DUTY_FLOOR =
		DUTY_W'(((64'd1 << DUTY_FRAC_BITS) * 64'd3) / 64'd4);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECOV_TIME = 2'd3;

	// Register reset values
	localparam logic [RATE_W-1:0]     RAMP_RATE_RST  = 16'd839;
	localparam logic [CFG_TIME_W-1:0] HOLD_TIME_RST  = 24'd10000;
	localparam logic [CFG_TIME_W-1:0] RECOV_TIME_RST = 24'd10000;

	// Reported phase codes
	localparam logic [PHASE_W-1:0] PHASE_OFF   = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_UP    = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_HOLD  = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_DOWN  = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_RECOV = 3'd4;

	typedef struct packed {
		logic                 req_type;
		logic [ELAPSED_W-1:0] elapsed_us;
		logic [DUTY_W-1:0]    start_duty;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty_out;
		logic [PHASE_W-1:0] phase;
		logic               active;
	} out_item_t;

endpackage

/* sv/short_circuit_duty_pulse_sequencer_core.sv */
// Short-circuit duty pulse sequencer.
// Input channel (in_valid / in_stall / in_data): each transaction is either a
// start request (req_type 1, loads start_duty while enabled) or a tick
// carrying the microseconds since the previous transaction.
// Output channel (out_valid / out_stall / out_data): exactly one transaction
// per input transaction, in order, giving the duty, the phase and the active
// flag after that input has been applied.
// Configuration: cfg_wr_en writes cfg_data to the register named by
// cfg_index (enable, ramp rate, hold time, recovery time); write only while
// no transaction is in flight.
// An accepted transaction lands in the input stage with its ramp step
// (rate times elapsed time); when the stage advances, it is applied to
// the sequencer state and fills the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the single update of phase, duty and timer per cycle sets that figure.
// When the receiver stalls, the output register holds its transaction; the
// input stage still takes one more transaction, after which in_stall rises.
// Reset clears both stages, sets the phase to off, the duty and timer to
// zero, and restores the register defaults.
module short_circuit_duty_pulse_sequencer_core #(
	parameter int TIMER_BITS = scdps_pkg::TIMER_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  scdps_pkg::in_item_t                   in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output scdps_pkg::out_item_t                  out_data,
	input  logic                                  cfg_wr_en,
	input  logic [scdps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [scdps_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DW    = scdps_pkg::DUTY_W;
	localparam int TEXT_W = (TIMER_BITS > scdps_pkg::CFG_TIME_W) ? TIMER_BITS :
		scdps_pkg::CFG_TIME_W;
	localparam int CMP_W = (TIMER_BITS > scdps_pkg::ELAPSED_W) ? TIMER_BITS :
		scdps_pkg::ELAPSED_W;
	localparam int SUM_W = scdps_pkg::DELTA_W + 1;
	localparam logic [TEXT_W-1:0] TIMER_MAX_EXT = TEXT_W'({TIMER_BITS{1'b1}});

	typedef enum logic [4:0] {
		ST_OFF   = 5'b00001,
		ST_UP    = 5'b00010,
		ST_HOLD  = 5'b00100,
		ST_DOWN  = 5'b01000,
		ST_RECOV = 5'b10000
	} seq_state_t;

	// Configuration registers
	logic                                 enable_q;
	logic [scdps_pkg::RATE_W-1:0]         ramp_rate_q;
	logic [scdps_pkg::CFG_TIME_W-1:0]     hold_time_q;
	logic [scdps_pkg::CFG_TIME_W-1:0]     recov_time_q;

	// Input stage
	logic                                 valid_s1;
	logic                                 req_s1;
	logic [scdps_pkg::ELAPSED_W-1:0]      elapsed_s1;
	logic [DW-1:0]                        start_duty_s1;
	logic [scdps_pkg::DELTA_W-1:0]        delta_s1;

	// Sequencer state
	seq_state_t                           state_q;
	logic [DW-1:0]                        duty_q;
	logic [TIMER_BITS-1:0]                timer_q;

	// Output register
	logic                                 out_valid_q;
	scdps_pkg::out_item_t                 out_data_q;

	logic                                 adv;
	logic                                 in_acc;
	logic [scdps_pkg::PROD_W-1:0]         prod;
	logic [TEXT_W-1:0]                    hold_ext;
	logic [TEXT_W-1:0]                    recov_ext;
	logic [TIMER_BITS-1:0]                hold_sat;
	logic [TIMER_BITS-1:0]                recov_sat;
	logic                                 timer_done;
	logic [TIMER_BITS-1:0]                timer_dec;
	logic [SUM_W-1:0]                     duty_sum;
	logic [DW-1:0]                        duty_above_floor;
	seq_state_t                           state_n;
	logic [DW-1:0]                        duty_n;
	logic [TIMER_BITS-1:0]                timer_n;
	logic [scdps_pkg::PHASE_W-1:0]        phase_code;

	// Handshake: the stage advances when the output slot is empty or drains
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			ramp_rate_q  <= scdps_pkg::RAMP_RATE_RST;
			hold_time_q  <= scdps_pkg::HOLD_TIME_RST;
			recov_time_q <= scdps_pkg::RECOV_TIME_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				scdps_pkg::REG_ENABLE:     enable_q     <= cfg_data[0];
				scdps_pkg::REG_RAMP_RATE:  ramp_rate_q  <= cfg_data[scdps_pkg::RATE_W-1:0];
				scdps_pkg::REG_HOLD_TIME:  hold_time_q  <= cfg_data[scdps_pkg::CFG_TIME_W-1:0];
				scdps_pkg::REG_RECOV_TIME: recov_time_q <= cfg_data[scdps_pkg::CFG_TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Ramp step for the incoming transaction
	assign prod = scdps_pkg::PROD_W'(ramp_rate_q) * scdps_pkg::PROD_W'(in_data.elapsed_us);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1        <= in_data.req_type;
			elapsed_s1    <= in_data.elapsed_us;
			start_duty_s1 <= in_data.start_duty;
			delta_s1      <= prod[scdps_pkg::PROD_W-1:scdps_pkg::RATE_SHIFT];
		end
	end

	// Saturate the configured times to the timer width
	assign hold_ext  = TEXT_W'(hold_time_q);
	assign recov_ext = TEXT_W'(recov_time_q);
	assign hold_sat  = (hold_ext > TIMER_MAX_EXT) ? TIMER_MAX_EXT[TIMER_BITS-1:0] :
		hold_ext[TIMER_BITS-1:0];
	assign recov_sat = (recov_ext > TIMER_MAX_EXT) ? TIMER_MAX_EXT[TIMER_BITS-1:0] :
		recov_ext[TIMER_BITS-1:0];

	// Count down by the elapsed time, stopping at zero
	assign timer_done = CMP_W'(elapsed_s1) >= CMP_W'(timer_q);
	assign timer_dec  = timer_q - TIMER_BITS'(elapsed_s1);

	assign duty_sum         = SUM_W'(duty_q) + SUM_W'(delta_s1);
	assign duty_above_floor = duty_q - scdps_pkg::DUTY_FLOOR;

	// Next sequencer state
	always_comb begin
		state_n = state_q;
		duty_n  = duty_q;
		timer_n = timer_q;
		if (req_s1) begin
			if (enable_q) begin
				state_n = ST_UP;
				duty_n  = (start_duty_s1 > scdps_pkg::DUTY_ONE) ? scdps_pkg::DUTY_ONE :
					start_duty_s1;
			end
		end else begin
			unique case (state_q)
				ST_OFF: ;
				ST_UP: begin
					if (duty_q > scdps_pkg::TH_HIGH) begin
						state_n = ST_HOLD;
						duty_n  = scdps_pkg::DUTY_ONE;
						timer_n = hold_sat;
					end else if (duty_sum > SUM_W'(scdps_pkg::DUTY_ONE)) begin
						duty_n = scdps_pkg::DUTY_ONE;
					end else begin
						duty_n = duty_sum[DW-1:0];
					end
				end
				ST_HOLD: begin
					duty_n  = scdps_pkg::DUTY_ONE;
					timer_n = timer_done ? '0 : timer_dec;
					if (timer_done) begin
						state_n = ST_DOWN;
					end
				end
				ST_DOWN: begin
					if (duty_q < scdps_pkg::TH_LOW) begin
						state_n = ST_RECOV;
						timer_n = recov_sat;
						duty_n  = '0;
					end else if (duty_q <= scdps_pkg::DUTY_FLOOR ||
						scdps_pkg::DELTA_W'(duty_above_floor) <= delta_s1) begin
						duty_n = scdps_pkg::DUTY_FLOOR;
					end else begin
						duty_n = duty_q - delta_s1[DW-1:0];
					end
				end
				ST_RECOV: begin
					timer_n = timer_done ? '0 : timer_dec;
					if (timer_done) begin
						state_n = ST_OFF;
					end
				end
				default: state_n = ST_OFF;
			endcase
		end
	end

	// Encode the reported phase
	always_comb begin
		unique case (state_n)
			ST_OFF:   phase_code = scdps_pkg::PHASE_OFF;
			ST_UP:    phase_code = scdps_pkg::PHASE_UP;
			ST_HOLD:  phase_code = scdps_pkg::PHASE_HOLD;
			ST_DOWN:  phase_code = scdps_pkg::PHASE_DOWN;
			ST_RECOV: phase_code = scdps_pkg::PHASE_RECOV;
			default:  phase_code = scdps_pkg::PHASE_OFF;
		endcase
	end

	// Apply the transaction to the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_OFF;
			duty_q  <= '0;
			timer_q <= '0;
		end else if (valid_s1 && adv) begin
			state_q <= state_n;
			duty_q  <= duty_n;
			timer_q <= timer_n;
		end
	end

	// Fill or drain the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_data_q.duty_out <= duty_n;
			out_data_q.phase    <= phase_code;
			out_data_q.active   <= (state_n != ST_OFF);
		end
	end

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while a stage was free");

	a_stage_kept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("input stage dropped a transaction under stall");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.duty_out <= scdps_pkg::DUTY_ONE))
		else $error("duty above full scale");

	a_active_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.active == (out_data_q.phase != scdps_pkg::PHASE_OFF)))
		else $error("active flag disagrees with phase");

	a_hold_full_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> (duty_q == scdps_pkg::DUTY_ONE))
		else $error("hold phase without full duty");
`endif

endmodule
